/* hdl/pbd_pkg.sv */
// Shared types and constants for the point-to-box distance query unit.
// Used by pbd_cfg_regs, pbd_axis and point_box_distance_query_unit.
package pbd_pkg;

  localparam int COORD_W = 32;   // signed Q16.16 coordinate
  localparam int HALF_W  = 31;   // unsigned Q15.16 half extent
  localparam int TOL_W   = 16;   // unsigned Q0.16 tolerance
  localparam int DIST_W  = 64;   // unsigned Q32.32 squared distance
  localparam int AXES    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_CENTER_Z  = 3'd2,
    CFG_HALF_X    = 3'd3,
    CFG_HALF_Y    = 3'd4,
    CFG_HALF_Z    = 3'd5,
    CFG_TOLERANCE = 3'd6
  } cfg_idx_t;

  // Point classification
  typedef enum logic [1:0] {
    REL_INSIDE  = 2'd0,
    REL_SURFACE = 2'd1,
    REL_OUTSIDE = 2'd2
  } rel_t;

  // Box description held in configuration
  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] center;
    logic [AXES-1:0][HALF_W-1:0]  half;
    logic [TOL_W-1:0]             tol;
  } cfg_t;

  // Per-axis result of the clamp stage
  typedef struct packed {
    logic [COORD_W-1:0] gap;       // distance outside the slab, unsigned
    logic [COORD_W-1:0] clamped;   // offset clamped to [-half, +half]
    logic               out_tol;   // excess above tolerance
    logic               in_tol;    // excess below minus tolerance
  } axis_t;

endpackage

/* hdl/pbd_cfg_regs.sv */
// Configuration register file for the point-to-box distance query unit.
// Depends on pbd_pkg for the register map and the cfg_t box type.
module pbd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]     wr_data,
  output pbd_pkg::cfg_t                      cfg
);
  import pbd_pkg::*;

  // Write one register per word; unknown indexes drop the word
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center <= '0;
      cfg.half   <= '0;
      cfg.tol    <= TOL_RESET;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_CENTER_X:  cfg.center[0] <= wr_data;
        CFG_CENTER_Y:  cfg.center[1] <= wr_data;
        CFG_CENTER_Z:  cfg.center[2] <= wr_data;
        CFG_HALF_X:    cfg.half[0]   <= wr_data[HALF_W-1:0];
        CFG_HALF_Y:    cfg.half[1]   <= wr_data[HALF_W-1:0];
        CFG_HALF_Z:    cfg.half[2]   <= wr_data[HALF_W-1:0];
        CFG_TOLERANCE: cfg.tol       <= wr_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/pbd_axis.sv */
// One axis of the box test: offset from center, clamp, gap and tolerance flags.
// Purely combinational; depends on pbd_pkg for axis_t and the field widths.
module pbd_axis (
  input  logic [pbd_pkg::COORD_W-1:0] point,
  input  logic [pbd_pkg::COORD_W-1:0] center,
  input  logic [pbd_pkg::HALF_W-1:0]  half,
  input  logic [pbd_pkg::TOL_W-1:0]   tol,
  output pbd_pkg::axis_t              res
);
  import pbd_pkg::*;

  localparam int W = COORD_W + 2;   // room for offset and its negation

  logic signed [W-1:0] d;
  logic signed [W-1:0] h;
  logic signed [W-1:0] nh;
  logic signed [W-1:0] t;
  logic signed [W-1:0] ad;
  logic signed [W-1:0] e;
  logic signed [W-1:0] gap_lo;
  logic signed [W-1:0] gap_hi;
  logic                below;
  logic                above;

  // Exact offset and extended bounds
  assign d = $signed({{2{point[COORD_W-1]}}, point}) - $signed({{2{center[COORD_W-1]}}, center});
  assign h  = $signed({{(W-HALF_W){1'b0}}, half});
  assign nh = -h;
  assign t  = $signed({{(W-TOL_W){1'b0}}, tol});

  assign below  = d < nh;
  assign above  = d > h;
  assign gap_lo = nh - d;
  assign gap_hi = d - h;

  // Excess of the offset magnitude over the half extent
  assign ad = d[W-1] ? -d : d;
  assign e  = ad - h;

  // Clamp and gap select
  always_comb begin
    res.out_tol = e > t;
    res.in_tol  = e < -t;
    priority if (below) begin
      res.gap     = gap_lo[COORD_W-1:0];
      res.clamped = nh[COORD_W-1:0];
    end else if (above) begin
      res.gap     = gap_hi[COORD_W-1:0];
      res.clamped = h[COORD_W-1:0];
    end else begin
      res.gap     = '0;
      res.clamped = d[COORD_W-1:0];
    end
  end

endmodule

/* hdl/point_box_distance_query_unit.sv */
// Top level of the point-to-box squared distance query unit.
// Depends on pbd_pkg, pbd_cfg_regs and pbd_axis.
//
// Usage:
//   Write the box (center, half extents, tolerance) on the configuration
//   channel while no query is in flight; cfg_ready is always high and one
//   word is taken per cycle. Each input word is one point; each output word
//   carries the squared distance to the box (Q32.32, saturating), the point's
//   offset from the center clamped to the box, and the inside / surface /
//   outside class.
//   Path: a point passes the input register, the clamp stage and the
//   squaring stage, then is summed into the output register.
//   Throughput: one point per cycle while the output is not stalled, set
//   by the four-register pipeline with one 32x32 squarer per axis.
//   Stall: a stalled output word holds; bubbles in the pipeline still close
//   up, and in_stall rises only once every stage holds a word.
//   Reset: clears all valid flags and sets the box to center 0, half
//   extents 0, tolerance 7.
module point_box_distance_query_unit (
  input  logic                                clk,
  input  logic                                rst,
  // query channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pbd_pkg::COORD_W-1:0]         point_x,
  input  logic [pbd_pkg::COORD_W-1:0]         point_y,
  input  logic [pbd_pkg::COORD_W-1:0]         point_z,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pbd_pkg::DIST_W-1:0]          squared_distance,
  output logic [pbd_pkg::COORD_W-1:0]         clamped_x,
  output logic [pbd_pkg::COORD_W-1:0]         clamped_y,
  output logic [pbd_pkg::COORD_W-1:0]         clamped_z,
  output logic [1:0]                          relation,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pbd_pkg::*;

  cfg_t cfg;

  // Stage 1: input register
  logic                             v1;
  logic [AXES-1:0][COORD_W-1:0]     pt;
  // Stage 2: clamp results
  logic                             v2;
  logic [AXES-1:0][COORD_W-1:0]     gap2;
  logic [AXES-1:0][COORD_W-1:0]     clamp2;
  rel_t                             rel2;
  // Stage 3: squares
  logic                             v3;
  logic [AXES-1:0][DIST_W-1:0]      sq3;
  logic [AXES-1:0][COORD_W-1:0]     clamp3;
  rel_t                             rel3;

  logic ready1, ready2, ready3, ready4;
  axis_t [AXES-1:0]                 ax;
  logic [AXES-1:0]                  out_tol;
  logic [AXES-1:0]                  in_tol;
  rel_t                             rel_next;
  logic [DIST_W+1:0]                sum;
  logic [DIST_W-1:0]                dist_next;

  assign cfg_ready = 1'b1;

  pbd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Each stage advances when empty or when the next one moves
  assign ready4   = !out_valid || !out_stall;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  // Hold the point
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
    if (in_valid && ready1) begin
      pt[0] <= point_x;
      pt[1] <= point_y;
      pt[2] <= point_z;
    end
  end

  // Clamp each axis against the box
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    pbd_axis u_axis (
      .point  (pt[a]),
      .center (cfg.center[a]),
      .half   (cfg.half[a]),
      .tol    (cfg.tol),
      .res    (ax[a])
    );
    assign out_tol[a] = ax[a].out_tol;
    assign in_tol[a]  = ax[a].in_tol;
  end

  // Classify: any axis beyond tolerance is outside, all well within is inside
  always_comb begin
    priority if (|out_tol) begin
      rel_next = REL_OUTSIDE;
    end else if (&in_tol) begin
      rel_next = REL_INSIDE;
    end else begin
      rel_next = REL_SURFACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
    if (v1 && ready2) begin
      for (int a = 0; a < AXES; a++) begin
        gap2[a]   <= ax[a].gap;
        clamp2[a] <= ax[a].clamped;
      end
      rel2 <= rel_next;
    end
  end

  // Square the gaps
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
    if (v2 && ready3) begin
      for (int a = 0; a < AXES; a++) begin
        sq3[a] <= DIST_W'(gap2[a]) * DIST_W'(gap2[a]);
      end
      clamp3 <= clamp2;
      rel3   <= rel2;
    end
  end

  // Sum the squares and saturate
  assign sum = {2'b00, sq3[0]} + {2'b00, sq3[1]} + {2'b00, sq3[2]};
  assign dist_next = (sum[DIST_W+1:DIST_W] != 2'b00) ? {DIST_W{1'b1}} : sum[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready4) begin
      out_valid <= v3;
    end
    if (v3 && ready4) begin
      squared_distance <= dist_next;
      clamped_x        <= clamp3[0];
      clamped_y        <= clamp3[1];
      clamped_z        <= clamp3[2];
      relation         <= rel3;
    end
  end

  // A point inside the box has zero distance
  a_inside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && relation == REL_INSIDE |-> squared_distance == '0)
    else $error("inside point with nonzero distance");

  // Input stalls only when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && v3 && out_valid)
    else $error("input stalled with a free pipeline stage");

  // An accepted point occupies the input register next cycle
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted point lost");

  // A stalled result keeps the stage behind it full
  a_hold_behind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && v3 |=> v3 && out_valid)
    else $error("word dropped behind a stalled output");

endmodule
